// ===== hw/rtl/dq_pkg.sv =====
// shared constants, codes and types of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

	localparam int DEPTH   = 1024;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int SW      = CW + 1;
	localparam int DW      = 32;
	localparam int IN_TW   = 40;
	localparam int OUT_TW  = 48;

	localparam logic [DW-1:0] NO_DATA = {DW{1'b1}};

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_STATUS     = 3'd6,
		OP_NONE       = 3'd7
	} op_t;

	// one port write, one port read per cycle
	typedef struct packed {
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [DW-1:0] wr_data;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
	} dq_ram_req_t;

	// wrap a sum below twice the depth back into the slot range
	function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] sum);
		logic [SW-1:0] adj;
		adj = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
		return adj[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// top level of the double-ended queue of signed 32-bit words
//
// usage:
//   requests arrive as beats on the s_axis channel, one request per beat:
//   push front, push back, pop front, pop back, peek front, peek back,
//   status or none. every request yields exactly one result beat on m_axis.
//   a result carries the popped or peeked word (-1 with has_value low when
//   there is nothing to return), the count after the request, an empty flag
//   and an overflow flag that marks a push dropped on a full queue.
//   pipeline: once its request is accepted, a result passes the synchronous
//   slot memory read and then the output register. throughput: one request
//   per cycle until a stall fills both stages; head pointer and count are
//   updated in the accept cycle, so the next request already sees them,
//   and the slot memory write lands before any later read of that slot.
//   stall: when m_axis_tready is low, the output register holds its beat and
//   the read stage holds a second one; s_axis_tready drops only when both
//   are full, so at most two requests are in flight.
//   reset: arst_n clears head pointer, count and all valid flags at once;
//   the slot memory is not cleared, a slot is read only after a push wrote it.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue
	import dq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_TW-1:0]  s_axis_tdata,   // operation[2:0], value[34:3], zero fill
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_TW-1:0]      m_axis_tdata    // data[31:0], has_value[32], count[43:33],
	                                               // is_empty[44], overflow[45], zero fill
);

	// request fields
	op_t           op;
	logic [DW-1:0] value;

	// queue pointers
	logic [AW-1:0] head_q;
	logic [CW-1:0] occ_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] occ_d;

	// read stage: waiting for memory data
	logic          valid_s1;
	logic          has_s1;
	logic          ovf_s1;
	logic [CW-1:0] count_s1;

	// output register
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;
	logic          out_has_q;
	logic          out_ovf_q;
	logic [CW-1:0] out_count_q;

	logic          in_fire;
	logic          s1_adv;
	logic          has_d;
	logic          ovf_d;
	logic          full;
	logic [DW-1:0] rd_data;
	dq_ram_req_t   ram_req;

	assign op    = op_t'(s_axis_tdata[2:0]);
	assign value = s_axis_tdata[34:3];
	assign full  = (occ_q == CW'(DEPTH));

	// read stage moves on when the output register is free or being drained
	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// request decode: slot access and next pointers
	always_comb begin
		logic [SW-1:0] tail_sum;
		logic [SW-1:0] back_sum;
		tail_sum        = SW'(head_q) + SW'(occ_q);
		back_sum        = tail_sum - SW'(1);
		head_d          = head_q;
		occ_d           = occ_q;
		has_d           = 1'b0;
		ovf_d           = 1'b0;
		ram_req.wr_en   = 1'b0;
		ram_req.wr_addr = head_q;
		ram_req.wr_data = value;
		ram_req.rd_en   = 1'b0;
		ram_req.rd_addr = head_q;
		unique case (op) inside
			OP_PUSH_FRONT: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					head_d          = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));
					occ_d           = occ_q + CW'(1);
					ram_req.wr_en   = in_fire;
					ram_req.wr_addr = head_d;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					occ_d           = occ_q + CW'(1);
					ram_req.wr_en   = in_fire;
					ram_req.wr_addr = wrap_idx(tail_sum);
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (occ_q != '0) begin
					has_d           = 1'b1;
					ram_req.rd_en   = in_fire;
					ram_req.rd_addr = head_q;
					if (op == OP_POP_FRONT) begin
						head_d = wrap_idx(SW'(head_q) + SW'(1));
						occ_d  = occ_q - CW'(1);
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (occ_q != '0) begin
					has_d           = 1'b1;
					ram_req.rd_en   = in_fire;
					ram_req.rd_addr = wrap_idx(back_sum);
					if (op == OP_POP_BACK) begin
						occ_d = occ_q - CW'(1);
					end
				end
			end
			default: begin
				// status and none leave the queue alone
			end
		endcase
	end

	dq_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// pointers and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			occ_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				head_q <= head_d;
				occ_q  <= occ_d;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result fields of the read stage and the output register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			has_s1   <= has_d;
			ovf_s1   <= ovf_d;
			count_s1 <= occ_d;
		end
		if (s1_adv) begin
			out_data_q  <= has_s1 ? rd_data : NO_DATA;
			out_has_q   <= has_s1;
			out_ovf_q   <= ovf_s1;
			out_count_q <= count_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_ovf_q, (out_count_q == '0), out_count_q,
		out_has_q, out_data_q};

endmodule
`default_nettype wire

// ===== hw/rtl/dq_ram.sv =====
// slot memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module dq_ram
	import dq_pkg::*;
(
	input  wire logic        clk,
	input  wire dq_ram_req_t req,
	output logic [DW-1:0]    rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dq_checker.sv =====
// port-level assertions of the double-ended queue and their binding
`timescale 1ns / 1ps
`default_nettype none
module dq_checker
	import dq_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [OUT_TW-1:0] m_axis_tdata
);

	logic [DW-1:0] r_data;
	logic          r_has;
	logic [CW-1:0] r_count;
	logic          r_empty;
	logic          r_ovf;

	assign r_data  = m_axis_tdata[31:0];
	assign r_has   = m_axis_tdata[32];
	assign r_count = m_axis_tdata[43:33];
	assign r_empty = m_axis_tdata[44];
	assign r_ovf   = m_axis_tdata[45];

	// a stalled result beat stays and keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// empty flag follows the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (r_empty == (r_count == '0)))
		else $error("empty flag disagrees with count");

	// no word means the all-ones marker
	a_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !r_has |-> (r_data == NO_DATA))
		else $error("missing word not shown as -1");

	// a dropped push returns no word and only happens at full depth
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r_ovf |-> !r_has && (r_count == CW'(DEPTH)))
		else $error("overflow without full queue");

	// count never exceeds the depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (r_count <= CW'(DEPTH)))
		else $error("count beyond depth");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
